/* src/egb_pkg.sv */
// Shared constants for the epsilon-greedy bandit agent.
// Field widths, stream packing, configuration register indexes and reset values.
// No dependencies.
package egb_pkg;

	// Parameter defaults
	localparam int NUM_ARMS_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 16;

	// Field widths
	localparam int CNT_W      = 16;
	localparam int OFS_W      = 4;
	localparam int ARM_IN_W   = 4;
	localparam int REWARD_W   = 16;
	localparam int EST_OUT_W  = 16;
	localparam int FSTEP_W    = 16;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 40;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP = 1'd1;

	// Reset values
	localparam logic [FSTEP_W-1:0] FIXED_STEP_RST = 16'd6554;

	// Item kinds and step modes
	localparam logic MODE_SELECT   = 1'b0;
	localparam logic MODE_REWARD   = 1'b1;
	localparam logic STEP_AVERAGE  = 1'b0;
	localparam logic STEP_CONSTANT = 1'b1;

endpackage

/* src/epsilon_greedy_bandit_agent.sv */
// Epsilon-greedy bandit agent: per-arm Q8.8 estimates and saturating counts.
// Depends on egb_pkg and egb_ram.
//
// Usage:
//   Input stream (s_*): tuser carries the kind (0 select, 1 reward); tdata carries
//   explore, explore_offset, arm and reward. Output stream (m_*): one transaction
//   per input transaction with action, estimate and pick_count.
//   A select scans all arms through the RAM read port, one arm per cycle, then
//   reduces greedy + offset modulo NUM_ARMS by repeated subtraction.
//   A reward reads the arm, forms |reward - estimate|, then runs the shared adder
//   as a restoring divider (VALUE_WIDTH+2 or 18 steps, whichever is larger) or as
//   a shift-add multiplier (16 steps), then adds and saturates.
//   A reward for an arm outside the table goes straight to the output.
//   One item is in work at a time; s_tready is high only while idle.
//   The result sits in an output register; a stalled receiver holds it, and the
//   next item may be accepted meanwhile but does not finish until it drains.
//   Reset clears the sequencer, the configuration and the per-arm valid bits,
//   so every arm reads as estimate zero, count zero. No clearing pass is needed.
//   Configuration is written through cfg_we/cfg_idx/cfg_wdata by the user, only
//   while idle; the block itself has no check that enforces this.
module epsilon_greedy_bandit_agent #(
	parameter int NUM_ARMS    = egb_pkg::NUM_ARMS_DEF,
	parameter int VALUE_WIDTH = egb_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port
	input  logic                               cfg_we,
	input  logic [egb_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [egb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// Input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// s_tdata: explore[0], explore_offset[4:1], arm[8:5], reward[24:9], zero fill
	input  logic [egb_pkg::S_TDATA_W-1:0]      s_tdata,
	// s_tuser: mode[0]
	input  logic [0:0]                         s_tuser,
	// Output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata: action[3:0], estimate[19:4], pick_count[35:20], zero fill
	output logic [egb_pkg::M_TDATA_W-1:0]      m_tdata
);

	import egb_pkg::*;

	localparam int ARM_W = $clog2(NUM_ARMS);
	localparam int VW    = VALUE_WIDTH;
	localparam int DW    = ((VW > CNT_W) ? VW : CNT_W) + 1;
	localparam int AW    = DW + 2;
	localparam int PW    = DW + 1;
	localparam int IW    = $clog2(PW + 1);
	localparam int SW    = ((ARM_W > OFS_W) ? ARM_W : OFS_W) + 1;
	localparam int MW    = CNT_W + VW;
	localparam int PAD_W = M_TDATA_W - CNT_W - EST_OUT_W - ARM_IN_W;

	localparam logic [ARM_W:0] N_IDX = (ARM_W + 1)'(NUM_ARMS);

	// Sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_MOD    = 4'd2;
	localparam logic [3:0] S_RDSEL  = 4'd3;
	localparam logic [3:0] S_OUTSEL = 4'd4;
	localparam logic [3:0] S_RDARM  = 4'd5;
	localparam logic [3:0] S_LOAD   = 4'd6;
	localparam logic [3:0] S_MAG    = 4'd7;
	localparam logic [3:0] S_PREP   = 4'd8;
	localparam logic [3:0] S_ITER   = 4'd9;
	localparam logic [3:0] S_ROUND  = 4'd10;
	localparam logic [3:0] S_SUM    = 4'd11;
	localparam logic [3:0] S_OUT    = 4'd12;

	logic [3:0] state_q;

	// Configuration
	logic               step_mode_q;
	logic [FSTEP_W-1:0] fixed_step_q;

	// Captured item
	logic                       explore_q;
	logic [OFS_W-1:0]           ofs_q;
	logic [ARM_IN_W-1:0]        arm_q;
	logic signed [REWARD_W-1:0] reward_q;

	// Scan and selection
	logic [ARM_W:0]         idx_q;
	logic [ARM_W-1:0]       best_idx_q;
	logic signed [VW-1:0]   best_est_q;
	logic [SW-1:0]          sel_q;

	// Update datapath
	logic signed [VW-1:0] est_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 neg_q;
	logic [DW-1:0]        mag_q;
	logic [AW-1:0]        acc_q;
	logic [PW-1:0]        shf_q;
	logic [IW-1:0]        iter_q;
	logic [DW-1:0]        q_q;

	// Result staging and output register
	logic [ARM_IN_W-1:0]  res_act_q;
	logic [EST_OUT_W-1:0] res_est_q;
	logic [CNT_W-1:0]     res_cnt_q;
	logic                 m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;

	// Arm store and its valid bits
	logic [NUM_ARMS-1:0] vld_q;
	logic                rd_vld_q;
	logic                ram_we;
	logic [ARM_W-1:0]    ram_waddr;
	logic [MW-1:0]       ram_wdata;
	logic                ram_re;
	logic [ARM_W-1:0]    ram_raddr;
	logic [MW-1:0]       ram_rdata;
	logic signed [VW-1:0] est_rd;
	logic [CNT_W-1:0]     cnt_rd;

	// Shared adder
	logic [AW-1:0] add_a;
	logic [AW-1:0] add_b;
	logic          add_ci;
	logic [AW-1:0] add_sum;

	// Derived control
	logic                 s_accept;
	logic                 scan_take;
	logic [ARM_W-1:0]     win_idx;
	logic [AW-1:0]        r_sh;
	logic                 qbit;
	logic                 ovf;
	logic signed [VW-1:0] sat_val;
	logic [CNT_W-1:0]     cnt_inc;

	egb_ram #(
		.WIDTH(MW),
		.DEPTH(NUM_ARMS)
	) u_arm_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// An entry never written reads as zero estimate, zero count
	assign est_rd  = rd_vld_q ? ram_rdata[VW-1:0] : '0;
	assign cnt_rd  = rd_vld_q ? ram_rdata[MW-1:VW] : '0;
	assign cnt_inc = (&cnt_rd) ? cnt_rd : cnt_rd + 1'b1;

	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign add_sum = add_a + add_b + AW'(add_ci);

	// Scan winner: first arm, or a strictly larger estimate
	assign scan_take = (idx_q == (ARM_W + 1)'(1)) || add_sum[AW-1];
	assign win_idx   = scan_take ? ARM_W'(idx_q - 1'b1) : best_idx_q;

	// Divider shift and trial subtract outcome
	assign r_sh = {acc_q[AW-2:0], shf_q[PW-1]};
	assign qbit = !add_sum[AW-1];

	// Saturate the adder result to the estimate width
	assign ovf     = !((&add_sum[AW-1:VW-1]) || !(|add_sum[AW-1:VW-1]));
	assign sat_val = ovf ? (add_sum[AW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
	                     : add_sum[VW-1:0];

	// Write back the updated arm
	assign ram_we    = (state_q == S_SUM);
	assign ram_waddr = ARM_W'(arm_q);
	assign ram_wdata = {cnt_q, sat_val};

	// Route operands to the shared adder and drive the read port
	always_comb begin
		add_a     = '0;
		add_b     = '0;
		add_ci    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_SCAN: begin
				ram_re    = (idx_q != N_IDX);
				ram_raddr = idx_q[ARM_W-1:0];
				add_a     = {{(AW-VW){best_est_q[VW-1]}}, best_est_q};
				add_b     = ~{{(AW-VW){est_rd[VW-1]}}, est_rd};
				add_ci    = 1'b1;
			end
			S_MOD: begin
				add_a  = AW'(sel_q);
				add_b  = ~AW'(N_IDX);
				add_ci = 1'b1;
			end
			S_RDSEL: begin
				ram_re    = 1'b1;
				ram_raddr = sel_q[ARM_W-1:0];
			end
			S_RDARM: begin
				ram_re    = 1'b1;
				ram_raddr = ARM_W'(arm_q);
			end
			S_LOAD: begin
				add_a  = {{(AW-REWARD_W){reward_q[REWARD_W-1]}}, reward_q};
				add_b  = ~{{(AW-VW){est_rd[VW-1]}}, est_rd};
				add_ci = 1'b1;
			end
			S_MAG: begin
				add_b  = ~acc_q;
				add_ci = 1'b1;
			end
			S_PREP: begin
				add_a = AW'({mag_q, 1'b0});
				add_b = AW'(cnt_q);
			end
			S_ITER: begin
				if (step_mode_q == STEP_AVERAGE) begin
					add_a  = r_sh;
					add_b  = ~AW'({cnt_q, 1'b0});
					add_ci = 1'b1;
				end else begin
					add_a = acc_q;
					add_b = shf_q[0] ? AW'(mag_q) : '0;
				end
			end
			S_ROUND: begin
				add_a  = acc_q;
				add_ci = shf_q[FSTEP_W-1];
			end
			S_SUM: begin
				add_a  = {{(AW-VW){est_q[VW-1]}}, est_q};
				add_b  = neg_q ? ~AW'(q_q) : AW'(q_q);
				add_ci = neg_q;
			end
			default: begin
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_mode_q  <= STEP_AVERAGE;
			fixed_step_q <= FIXED_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_STEP_MODE:  step_mode_q  <= cfg_wdata[0];
				CFG_FIXED_STEP: fixed_step_q <= FSTEP_W'(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	// Arm valid bits and the valid flag of the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rd_vld_q <= vld_q[ram_raddr];
			end
		end
	end

	// Sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			idx_q     <= '0;
			iter_q    <= '0;
		end else begin
			// Drop the output transaction once taken, unless a new one replaces it
			if (m_valid_q && m_tready && (state_q != S_OUT)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						idx_q <= '0;
						if (s_tuser[0] == MODE_SELECT) begin
							state_q <= S_SCAN;
						end else if (int'(s_tdata[8:5]) >= NUM_ARMS) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_RDARM;
						end
					end
				end
				S_SCAN: begin
					if (idx_q == N_IDX) begin
						state_q <= S_MOD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_MOD: begin
					if (add_sum[AW-1]) begin
						state_q <= S_RDSEL;
					end
				end
				S_RDSEL:  state_q <= S_OUTSEL;
				S_OUTSEL: state_q <= S_OUT;
				S_RDARM:  state_q <= S_LOAD;
				S_LOAD:   state_q <= S_MAG;
				S_MAG:    state_q <= S_PREP;
				S_PREP: begin
					iter_q  <= (step_mode_q == STEP_AVERAGE) ? IW'(PW) : IW'(FSTEP_W);
					state_q <= S_ITER;
				end
				S_ITER: begin
					iter_q <= iter_q - 1'b1;
					if (iter_q == IW'(1)) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: state_q <= S_SUM;
				S_SUM:   state_q <= S_OUT;
				S_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_accept) begin
					explore_q <= s_tdata[0];
					ofs_q     <= s_tdata[4:1];
					arm_q     <= s_tdata[8:5];
					reward_q  <= s_tdata[24:9];
					res_act_q <= s_tdata[8:5];
					res_est_q <= '0;
					res_cnt_q <= '0;
				end
			end
			S_SCAN: begin
				if (idx_q != '0) begin
					best_idx_q <= win_idx;
					if (scan_take) begin
						best_est_q <= est_rd;
					end
				end
				if (idx_q == N_IDX) begin
					sel_q <= SW'(win_idx) + (explore_q ? SW'(ofs_q) : '0);
				end
			end
			S_MOD: begin
				if (!add_sum[AW-1]) begin
					sel_q <= SW'(add_sum);
				end
			end
			S_OUTSEL: begin
				res_act_q <= ARM_IN_W'(sel_q);
				res_est_q <= EST_OUT_W'(est_rd);
				res_cnt_q <= cnt_rd;
			end
			S_LOAD: begin
				est_q <= est_rd;
				cnt_q <= cnt_inc;
				acc_q <= add_sum;
			end
			S_MAG: begin
				neg_q <= acc_q[AW-1];
				mag_q <= acc_q[AW-1] ? add_sum[DW-1:0] : acc_q[DW-1:0];
			end
			S_PREP: begin
				acc_q <= '0;
				if (step_mode_q == STEP_AVERAGE) begin
					shf_q <= add_sum[PW-1:0];
				end else begin
					shf_q <= PW'(fixed_step_q);
				end
			end
			S_ITER: begin
				if (step_mode_q == STEP_AVERAGE) begin
					// Restoring divide: keep the trial difference when it stays non-negative
					acc_q <= qbit ? add_sum : r_sh;
					shf_q <= {shf_q[PW-2:0], qbit};
				end else begin
					// Shift-add multiply, multiplier bits leave at the bottom
					acc_q              <= {1'b0, add_sum[AW-1:1]};
					shf_q[FSTEP_W-1:0] <= {add_sum[0], shf_q[FSTEP_W-1:1]};
				end
			end
			S_ROUND: begin
				q_q <= (step_mode_q == STEP_AVERAGE) ? shf_q[DW-1:0] : add_sum[DW-1:0];
			end
			S_SUM: begin
				res_act_q <= arm_q;
				res_est_q <= EST_OUT_W'(sat_val);
				res_cnt_q <= cnt_q;
			end
			S_OUT: begin
				if (!m_valid_q || m_tready) begin
					m_data_q <= {{PAD_W{1'b0}}, res_cnt_q, res_est_q, res_act_q};
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// One item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_tready)
		else $error("input accepted while an item was in work");

	// The step counter never runs the shared unit past its last step
	a_iter_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER) |-> (iter_q != '0))
		else $error("iteration count exhausted inside the step loop");

	// The divisor comes from a count that was just incremented
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER && step_mode_q == STEP_AVERAGE) |-> (cnt_q != '0))
		else $error("sample-average divide by a zero count");

	// The modulo reduction ends inside the arm table
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDSEL) |-> (sel_q < SW'(NUM_ARMS)))
		else $error("selected arm outside the table");

	// A write-back always targets an arm inside the table
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (int'(arm_q) < NUM_ARMS))
		else $error("write-back to an arm outside the table");
`endif

endmodule

/* src/egb_ram.sv */
// Generic RAM with one write port and one registered read port.
// Used for the per-arm estimate and count store. No dependencies.
module egb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then read with a registered output that holds when not enabled
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
